>>> hw/rtl/wfr_pkg.sv
// Shared types, constants and codes for the weighted field reduction block.
package wfr_pkg;

	// Sample and field widths
	localparam int SAMPLE_BITS = 32;
	localparam int WEIGHT_W    = 8;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int FRAC_W      = 16;
	localparam int SUM_W       = 64;

	// Configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_VOLUME    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INV_BOX_VOLUME = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] CELL_VOLUME_RST    = CFG_W'(65536);
	localparam logic [CFG_W-1:0] INV_BOX_VOLUME_RST = CFG_W'(65536);

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_INTEGRAL     = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_INNER        = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_INV_WEIGHTED = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_MEAN         = MODE_W'(3);

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK   = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STATUS_SAT  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STATUS_ZDIV = STATUS_W'(2);

	// Digit-serial multiplier geometry
	localparam int DIG_W    = 32;
	localparam int MUL_XDIG = 4;
	localparam int MUL_YDIG = 2;
	localparam int PROD_W   = MUL_XDIG * DIG_W;
	localparam int MUL_YW   = MUL_YDIG * DIG_W;
	localparam int XIDX_W   = $clog2(MUL_XDIG);
	localparam int YIDX_W   = $clog2(MUL_YDIG);

	// Divider: quotient bits and bits retired per step
	localparam int QUO_W       = SUM_W;
	localparam int RADIX_BITS  = 2;

	typedef struct packed {
		logic [MODE_W-1:0]             mode;
		logic signed [SAMPLE_BITS-1:0] field_g;
		logic signed [SAMPLE_BITS-1:0] field_h;
		logic signed [SAMPLE_BITS-1:0] field_w;
		logic [WEIGHT_W-1:0]           element_weight;
		logic                          last_element;
	} elem_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] reduction_result;
		logic [STATUS_W-1:0]     status;
	} result_t;

	typedef struct packed {
		logic [MUL_XDIG-1:0][DIG_W-1:0] x;
		logic [MUL_YDIG-1:0][DIG_W-1:0] y;
		logic [XIDX_W-1:0]              x_last;
		logic [YIDX_W-1:0]              y_last;
	} mul_cmd_t;

endpackage

>>> hw/rtl/wfr_mul.sv
// Digit-serial multi-precision multiplier: one 32x32 product per cycle.
module wfr_mul
	import wfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mul_cmd_t          cmd,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	localparam int OFF_W = $clog2(MUL_XDIG + MUL_YDIG - 1);

	logic [MUL_XDIG-1:0][DIG_W-1:0] x_q;
	logic [MUL_YDIG-1:0][DIG_W-1:0] y_q;
	logic [XIDX_W-1:0]              x_last_q;
	logic [YIDX_W-1:0]              y_last_q;
	logic [XIDX_W-1:0]              i_q;
	logic [YIDX_W-1:0]              j_q;
	logic                           issue_q;
	logic                           pv_s1;
	logic                           fin_s1;
	logic                           done_q;
	logic [2*DIG_W-1:0]             prod_s1;
	logic [OFF_W-1:0]               off_s1;
	logic [PROD_W-1:0]              acc_q;
	logic                           last_issue;

	assign last_issue = (i_q == x_last_q) && (j_q == y_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			pv_s1   <= 1'b0;
			fin_s1  <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= pv_s1 && fin_s1;
			pv_s1  <= issue_q;
			fin_s1 <= issue_q && last_issue;
			if (start) begin
				issue_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
			end else if (issue_q) begin
				if (i_q == x_last_q) begin
					i_q <= '0;
					j_q <= j_q + 1'b1;
					if (j_q == y_last_q) begin
						issue_q <= 1'b0;
					end
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// partial product registered, then shifted into place and summed
	always_ff @(posedge clk) begin
		if (start) begin
			x_q      <= cmd.x;
			y_q      <= cmd.y;
			x_last_q <= cmd.x_last;
			y_last_q <= cmd.y_last;
		end
		prod_s1 <= x_q[i_q] * y_q[j_q];
		off_s1  <= OFF_W'(i_q) + OFF_W'(j_q);
		if (start) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + (PROD_W'(prod_s1) << (DIG_W * off_s1));
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> hw/rtl/wfr_div.sv
// Radix-4 restoring divider with up-front quotient overflow check.
module wfr_div
	import wfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [PROD_W-1:0]      num,
	input  logic [SAMPLE_BITS-1:0] den,
	output logic                   done,
	output logic                   ovf,
	output logic [QUO_W-1:0]       quo
);

	localparam int DIV_STEPS = QUO_W / RADIX_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int R_W       = SAMPLE_BITS + RADIX_BITS;

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] d_q;
	logic [R_W-1:0]         d3_q;
	logic [QUO_W-1:0]       lo_q;
	logic [QUO_W-1:0]       quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   ovf_q;

	logic [R_W-1:0]        r4;
	logic [R_W-1:0]        d2;
	logic [R_W-1:0]        d1;
	logic [R_W-1:0]        sub;
	logic [R_W-1:0]        rem_n;
	logic [RADIX_BITS-1:0] dig;
	logic                  hi_ge;

	assign hi_ge = num[PROD_W-1:QUO_W] >= (PROD_W - QUO_W)'(den);
	assign r4    = {rem_q, lo_q[QUO_W-1 -: RADIX_BITS]};
	assign d2    = {1'b0, d_q, 1'b0};
	assign d1    = {2'b00, d_q};

	always_comb begin
		if (r4 >= d3_q) begin
			dig = 2'd3;
			sub = d3_q;
		end else if (r4 >= d2) begin
			dig = 2'd2;
			sub = d2;
		end else if (r4 >= d1) begin
			dig = 2'd1;
			sub = d1;
		end else begin
			dig = 2'd0;
			sub = '0;
		end
		rem_n = r4 - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				ovf_q  <= hi_ge;
				busy_q <= !hi_ge;
				done_q <= hi_ge;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= (cnt_q != CNT_W'(DIV_STEPS - 1));
				done_q <= (cnt_q == CNT_W'(DIV_STEPS - 1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[QUO_W +: SAMPLE_BITS];
			lo_q  <= num[QUO_W-1:0];
			d_q   <= den;
			d3_q  <= R_W'(den) + R_W'({den, 1'b0});
		end else if (busy_q) begin
			rem_q <= rem_n[SAMPLE_BITS-1:0];
			lo_q  <= lo_q << RADIX_BITS;
			quo_q <= {quo_q[QUO_W-RADIX_BITS-1:0], dig};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/weighted_field_reduction.sv
// Top level of the weighted field reduction block: sequencer, accumulator, config registers.
//
// Usage
//   Element channel (elem_valid / elem_stall / elem_data): one grid element per
//   transaction, taken when valid is high and stall is low. elem_stall stays high
//   while an element is being worked on; one element is in flight at a time.
//   Result channel (result_valid / result_stall / result_data): one transaction
//   per element marked last_element, carrying the scaled sum and the run status.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; index 0 is cell_volume, index 1 is inverse_box_volume, other
//   indexes are dropped. Write only while the block is idle.
// Work (32-bit samples): integral and mean take one product per element, inner
//   product two, inverse-weighted two and a division. The divider's 32 radix-4
//   steps set the slowest case; a shared 32x32 multiplier does all products one
//   digit pair per cycle. A last element adds scaling by the volume registers.
// Reset: accumulator and flags cleared, both volume registers set to 1.0.
// Backpressure: a result waits in an output register while result_stall is high;
//   the next elements are still taken, and only a following last element waits
//   in its final step until the output register is free.
module weighted_field_reduction
	import wfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 elem_valid,
	output logic                 elem_stall,
	input  elem_t                elem_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// digit counts of each multiplier operand
	localparam int G_DIG   = (SAMPLE_BITS + DIG_W - 1) / DIG_W;
	localparam int WG_W    = SAMPLE_BITS + WEIGHT_W;
	localparam int WG_DIG  = (WG_W + DIG_W - 1) / DIG_W;
	localparam int SUM_DIG = (SUM_W + DIG_W - 1) / DIG_W;
	localparam int SC_DIG  = (SUM_W + CFG_W + DIG_W - 1) / DIG_W;

	localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [PROD_W-1:0] OVF_MAG  = PROD_W'(1) << SUM_W;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WG   = 4'd1;   // weight * g
	localparam logic [3:0] S_WGH  = 4'd2;   // (weight * g) * h
	localparam logic [3:0] S_DIV  = 4'd3;   // divide by w
	localparam logic [3:0] S_TERM = 4'd4;   // saturate term to 64 bits
	localparam logic [3:0] S_ACC  = 4'd5;   // saturating accumulate
	localparam logic [3:0] S_SMAG = 4'd6;   // sum magnitude into multiplier
	localparam logic [3:0] S_SC1  = 4'd7;   // * cell_volume
	localparam logic [3:0] S_SC2  = 4'd8;   // * inverse_box_volume (mean)
	localparam logic [3:0] S_FIN  = 4'd9;   // saturate and emit

	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic             sat;
	} sat_res_t;

	function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
		return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : v;
	endfunction

	// signed-magnitude to signed 64-bit, saturating; a zero magnitude is positive
	function automatic sat_res_t to_sum(input logic [PROD_W-1:0] m, input logic neg);
		sat_res_t         r;
		logic             hi_nz;
		logic [SUM_W-1:0] lo;
		hi_nz   = |m[PROD_W-1:SUM_W];
		lo      = m[SUM_W-1:0];
		r.sat   = 1'b0;
		r.value = lo;
		if (neg && (hi_nz || lo != '0)) begin
			if (hi_nz || lo > SUM_MIN) begin
				r.sat   = 1'b1;
				r.value = SUM_MIN;
			end else begin
				r.value = ~lo + 1'b1;
			end
		end else if (hi_nz || lo > SUM_MAX) begin
			r.sat   = 1'b1;
			r.value = SUM_MAX;
		end
		return r;
	endfunction

	logic [3:0]             state_q;
	logic [MODE_W-1:0]      mode_q;
	logic                   last_q;
	logic                   neg_q;
	logic                   wzero_q;
	logic [SAMPLE_BITS-1:0] h_mag_q;
	logic [SAMPLE_BITS-1:0] w_mag_q;
	logic [PROD_W-1:0]      mag_q;
	logic [SUM_W-1:0]       term_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   sat_q;
	logic                   zdiv_q;
	logic [CFG_W-1:0]       cell_q;
	logic [CFG_W-1:0]       inv_q;
	result_t                result_q;
	logic                   result_valid_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] g_mag;
	logic [SUM_W-1:0]       smag;
	logic                   need_wgh;
	sat_res_t               sat_res;
	logic [SUM_W-1:0]       acc_sum;
	logic                   acc_ovf;

	logic                   mul_start;
	mul_cmd_t               mul_cmd;
	logic                   mul_done;
	logic [PROD_W-1:0]      mul_prod;

	logic                   div_start;
	logic                   div_done;
	logic                   div_ovf;
	logic [QUO_W-1:0]       div_quo;

	assign elem_stall   = (state_q != S_IDLE);
	assign accept       = elem_valid && !elem_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign g_mag    = mag_of(elem_data.field_g);
	assign smag     = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign need_wgh = (mode_q == MODE_INNER) || ((mode_q == MODE_INV_WEIGHTED) && !wzero_q);
	assign sat_res  = to_sum(mag_q, neg_q);

	// saturating accumulate: overflow only when both operands share a sign
	assign acc_sum = sum_q + term_q;
	assign acc_ovf = (sum_q[SUM_W-1] == term_q[SUM_W-1]) &&
	                 (acc_sum[SUM_W-1] != term_q[SUM_W-1]);

	// multiplier commands, one per product of the sequence
	always_comb begin
		mul_cmd   = '0;
		mul_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				mul_cmd.x      = PROD_W'(g_mag);
				mul_cmd.y      = MUL_YW'(elem_data.element_weight);
				mul_cmd.x_last = XIDX_W'(G_DIG - 1);
				mul_start      = accept;
			end
			S_WG: begin
				mul_cmd.x      = mul_prod;
				mul_cmd.y      = MUL_YW'(h_mag_q);
				mul_cmd.x_last = XIDX_W'(WG_DIG - 1);
				mul_cmd.y_last = YIDX_W'(G_DIG - 1);
				mul_start      = mul_done && need_wgh;
			end
			S_SMAG: begin
				mul_cmd.x      = PROD_W'(smag);
				mul_cmd.y      = MUL_YW'(cell_q);
				mul_cmd.x_last = XIDX_W'(SUM_DIG - 1);
				mul_start      = 1'b1;
			end
			S_SC1: begin
				mul_cmd.x      = mul_prod;
				mul_cmd.y      = MUL_YW'(inv_q);
				mul_cmd.x_last = XIDX_W'(SC_DIG - 1);
				mul_start      = mul_done && (mode_q == MODE_MEAN);
			end
			default: begin
			end
		endcase
	end

	// numerator carries the extra Q16 shift so the quotient lands in Q32.32
	assign div_start = (state_q == S_WGH) && mul_done && (mode_q == MODE_INV_WEIGHTED);

	wfr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.cmd    (mul_cmd),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	wfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_prod << FRAC_W),
		.den    (w_mag_q),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= MODE_INTEGRAL;
			last_q         <= 1'b0;
			neg_q          <= 1'b0;
			wzero_q        <= 1'b0;
			h_mag_q        <= '0;
			w_mag_q        <= '0;
			mag_q          <= '0;
			term_q         <= '0;
			sum_q          <= '0;
			sat_q          <= 1'b0;
			zdiv_q         <= 1'b0;
			cell_q         <= CELL_VOLUME_RST;
			inv_q          <= INV_BOX_VOLUME_RST;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// the final step reloads the output register itself
			if (result_valid_q && !result_stall && state_q != S_FIN) begin
				result_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CELL_VOLUME:    cell_q <= cfg_data;
					REG_INV_BOX_VOLUME: inv_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= elem_data.mode;
						last_q  <= elem_data.last_element;
						h_mag_q <= mag_of(elem_data.field_h);
						w_mag_q <= mag_of(elem_data.field_w);
						wzero_q <= (elem_data.field_w == '0);
						case (elem_data.mode) inside
							MODE_INNER: neg_q <= elem_data.field_g[SAMPLE_BITS-1] ^
							                     elem_data.field_h[SAMPLE_BITS-1];
							MODE_INV_WEIGHTED: neg_q <= elem_data.field_g[SAMPLE_BITS-1] ^
							                            elem_data.field_h[SAMPLE_BITS-1] ^
							                            elem_data.field_w[SAMPLE_BITS-1];
							default: neg_q <= elem_data.field_g[SAMPLE_BITS-1];
						endcase
						state_q <= S_WG;
					end
				end
				S_WG: begin
					if (mul_done) begin
						case (mode_q) inside
							MODE_INTEGRAL, MODE_MEAN: begin
								mag_q   <= mul_prod << FRAC_W;
								state_q <= S_TERM;
							end
							default: begin
								if (need_wgh) begin
									state_q <= S_WGH;
								end else begin
									// zero divisor: term is zero, flag the run
									mag_q   <= '0;
									zdiv_q  <= 1'b1;
									state_q <= S_TERM;
								end
							end
						endcase
					end
				end
				S_WGH: begin
					if (mul_done) begin
						if (mode_q == MODE_INNER) begin
							mag_q   <= mul_prod;
							state_q <= S_TERM;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						mag_q   <= div_ovf ? OVF_MAG : PROD_W'(div_quo);
						state_q <= S_TERM;
					end
				end
				S_TERM: begin
					term_q <= sat_res.value;
					if (sat_res.sat) begin
						sat_q <= 1'b1;
					end
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (acc_ovf) begin
						sum_q <= term_q[SUM_W-1] ? SUM_MIN : SUM_MAX;
						sat_q <= 1'b1;
					end else begin
						sum_q <= acc_sum;
					end
					state_q <= last_q ? S_SMAG : S_IDLE;
				end
				S_SMAG: begin
					neg_q   <= sum_q[SUM_W-1];
					state_q <= S_SC1;
				end
				S_SC1: begin
					if (mul_done) begin
						if (mode_q == MODE_MEAN) begin
							state_q <= S_SC2;
						end else begin
							mag_q   <= mul_prod >> FRAC_W;
							state_q <= S_FIN;
						end
					end
				end
				S_SC2: begin
					if (mul_done) begin
						mag_q   <= mul_prod >> (2 * FRAC_W);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!result_valid_q || !result_stall) begin
						result_q.reduction_result <= sat_res.value;
						if (zdiv_q) begin
							result_q.status <= STATUS_ZDIV;
						end else if (sat_q || sat_res.sat) begin
							result_q.status <= STATUS_SAT;
						end else begin
							result_q.status <= STATUS_OK;
						end
						result_valid_q <= 1'b1;
						sum_q          <= '0;
						sat_q          <= 1'b0;
						zdiv_q         <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WG || state_q == S_WGH ||
		              state_q == S_SC1 || state_q == S_SC2))
		else $error("multiplier finished outside a multiply wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WG))
		else $error("accepted element did not start the weight product");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside the final step");

endmodule
